// ===== rtl/core/synth_voice_allocator_defines.svh =====
// assertion macros for the voice allocator
`ifndef SYNTH_VOICE_ALLOCATOR_DEFINES_SVH
`define SYNTH_VOICE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// concurrent check on a given clock and active-low reset
`define SVALLOC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check on the block clock and reset
`define SVALLOC_ASSERT_STD(lbl, prop, msg) \
  `SVALLOC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`else

`define SVALLOC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SVALLOC_ASSERT_STD(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/svalloc_pkg.sv =====
// shared types and constants of the voice allocator
`timescale 1ns / 1ps
`default_nettype none

package svalloc_pkg;

  localparam int unsigned DEF_NUM_VOICES = 8;
  localparam int unsigned DEF_HELD_DEPTH = 16;

  // event codes
  localparam logic [1:0] CMD_NOTE_OFF = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_ALL_OFF  = 2'd2;
  localparam logic [1:0] CMD_REPORT   = 2'd3;

  // voice assignment modes
  localparam logic [1:0] MODE_POLY   = 2'd0;
  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_LEGATO = 2'd2;
  localparam logic [1:0] MODE_RESET  = MODE_LEGATO;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DROP_INIT,
    OP_DROP_RD,
    OP_DROP_WR,
    OP_DROP_END,
    OP_POLY_REL,
    OP_MONO_REL,
    OP_TAIL_RD,
    OP_MONO_TAIL,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_NOTE_ON,
    OP_ALL_OFF,
    OP_REPORT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] eff_cmd;
    logic [1:0] mode;
    logic       cnt_zero;
    logic       drop_done;
    logic       scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/synth_voice_allocator.sv =====
// top level of the polyphonic voice allocator
`timescale 1ns / 1ps
`default_nettype none

// Voice allocator for a polyphonic synth. Each input transaction is one event:
// note off, note on, all notes off, or a level report for one voice. Each event
// produces exactly one result transaction naming the voice to start or retune
// and a mask of voices entering release; quiet events return all-zero results.
// In poly mode a note on goes to the released voice with the lowest reported
// level (any voice if none is released), lowest index on ties; mono and legato
// drive voice 0 with last-note priority from a held-note list.
// Timing: one event at a time. Level report, all notes off and non-poly note
// on go from dispatch to emit; a poly note on first runs the voice scan, which
// checks one voice per cycle; a note off first runs the compaction walk over
// the held-list ram, which reads each entry and rewrites those it keeps through
// its single read port; in mono/legato it then reads the list tail when notes
// remain held. A finished result waits in the output register, so the next
// event is accepted while it is stalled. The held-note list needs no clearing
// after reset.
module synth_voice_allocator #(
  parameter int unsigned NUM_VOICES = svalloc_pkg::DEF_NUM_VOICES,
  parameter int unsigned HELD_DEPTH = svalloc_pkg::DEF_HELD_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: voice mode register
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  // event input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  note_number_i,
  input  logic [6:0]  note_velocity_i,
  input  logic [2:0]  report_voice_i,
  input  logic [15:0] report_level_i,
  // result output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        start_voice_o,
  output logic        assign_note_o,
  output logic [2:0]  target_index_o,
  output logic [6:0]  target_note_o,
  output logic [6:0]  target_velocity_o,
  output logic        reset_pitch_o,
  output logic [7:0]  release_mask_o
);

  import svalloc_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    ctl;
  dp_status_t sts;

  // sequencer: walks each transaction through the steps its event needs (list
  // compaction, voice scan, update), then hands the result to the output register
  svalloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // datapath: voice notes, release flags, levels, held-note ram, results
  svalloc_dp #(
    .NUM_VOICES (NUM_VOICES),
    .HELD_DEPTH (HELD_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd_i),
    .note_number_i     (note_number_i),
    .note_velocity_i   (note_velocity_i),
    .report_voice_i    (report_voice_i),
    .report_level_i    (report_level_i),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .start_voice_o     (start_voice_o),
    .assign_note_o     (assign_note_o),
    .target_index_o    (target_index_o),
    .target_note_o     (target_note_o),
    .target_velocity_o (target_velocity_o),
    .reset_pitch_o     (reset_pitch_o),
    .release_mask_o    (release_mask_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/svalloc_ram.sv =====
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module svalloc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/svalloc_ctrl.sv =====
// sequencing state machine of the voice allocator
`timescale 1ns / 1ps
`default_nettype none
`include "synth_voice_allocator_defines.svh"

module svalloc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  svalloc_pkg::dp_status_t sts_i,
  output svalloc_pkg::dp_cmd_t    ctl_o
);

  import svalloc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DROP_RD,
    ST_DROP_WR,
    ST_OFF_ACT,
    ST_TAIL_WAIT,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t ctl;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    ctl.op      = OP_NONE;
    ctl.emit    = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl.op  = OP_LATCH;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.eff_cmd)
          CMD_NOTE_OFF: begin
            ctl.op  = OP_DROP_INIT;
            state_d = ST_DROP_RD;
          end
          CMD_NOTE_ON: begin
            if (sts_i.mode == MODE_POLY) begin
              ctl.op  = OP_SCAN_INIT;
              state_d = ST_SCAN;
            end else begin
              ctl.op  = OP_NOTE_ON;
              state_d = ST_EMIT;
            end
          end
          CMD_ALL_OFF: begin
            ctl.op  = OP_ALL_OFF;
            state_d = ST_EMIT;
          end
          default: begin
            ctl.op  = OP_REPORT;
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_DROP_RD: begin
        if (sts_i.drop_done) begin
          ctl.op  = OP_DROP_END;
          state_d = ST_OFF_ACT;
        end else begin
          ctl.op  = OP_DROP_RD;
          state_d = ST_DROP_WR;
        end
      end
      ST_DROP_WR: begin
        ctl.op  = OP_DROP_WR;
        state_d = ST_DROP_RD;
      end
      ST_OFF_ACT: begin
        case (sts_i.mode)
          MODE_POLY: begin
            ctl.op  = OP_POLY_REL;
            state_d = ST_EMIT;
          end
          MODE_MONO, MODE_LEGATO: begin
            if (sts_i.cnt_zero) begin
              ctl.op  = OP_MONO_REL;
              state_d = ST_EMIT;
            end else begin
              ctl.op  = OP_TAIL_RD;
              state_d = ST_TAIL_WAIT;
            end
          end
          default: begin
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_TAIL_WAIT: begin
        ctl.op  = OP_MONO_TAIL;
        state_d = ST_EMIT;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          ctl.op  = OP_NOTE_ON;
          state_d = ST_EMIT;
        end else begin
          ctl.op  = OP_SCAN_STEP;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          ctl.emit    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign ctl_o       = ctl;

  `SVALLOC_ASSERT_STD(a_accept_dispatch, (in_valid_i && !in_stall_o) |=> (state_q == ST_DISPATCH), "accepted transaction not dispatched")
  `SVALLOC_ASSERT_STD(a_emit_valid, (state_q == ST_EMIT && (!out_valid_q || !out_stall_i)) |=> out_valid_q, "emitted result not presented")
  `SVALLOC_ASSERT_STD(a_stalled_result_held, (out_valid_q && out_stall_i) |=> out_valid_q, "stalled result dropped")

endmodule

`default_nettype wire

// ===== rtl/core/svalloc_dp.sv =====
// voice state, held-note list and result registers of the voice allocator
`timescale 1ns / 1ps
`default_nettype none
`include "synth_voice_allocator_defines.svh"

module svalloc_dp #(
  parameter int unsigned NUM_VOICES = svalloc_pkg::DEF_NUM_VOICES,
  parameter int unsigned HELD_DEPTH = svalloc_pkg::DEF_HELD_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_wdata_i,
  input  logic [1:0]              cmd_i,
  input  logic [6:0]              note_number_i,
  input  logic [6:0]              note_velocity_i,
  input  logic [2:0]              report_voice_i,
  input  logic [15:0]             report_level_i,
  input  svalloc_pkg::dp_cmd_t    ctl_i,
  output svalloc_pkg::dp_status_t sts_o,
  output logic                    start_voice_o,
  output logic                    assign_note_o,
  output logic [2:0]              target_index_o,
  output logic [6:0]              target_note_o,
  output logic [6:0]              target_velocity_o,
  output logic                    reset_pitch_o,
  output logic [7:0]              release_mask_o
);

  import svalloc_pkg::*;

  localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned SW = $clog2(NUM_VOICES + 1);
  localparam int unsigned AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HELD_DEPTH + 1);

  // control state
  logic [1:0]            mode_q, mode_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [CW-1:0]         rd_q, rd_d;
  logic [CW-1:0]         wr_q, wr_d;
  logic [SW-1:0]         si_q, si_d;
  logic [6:0]            vnote_q [NUM_VOICES];
  logic [6:0]            vnote_d [NUM_VOICES];
  logic [NUM_VOICES-1:0] vrel_q, vrel_d;
  logic [15:0]           vlvl_q [NUM_VOICES];
  logic [15:0]           vlvl_d [NUM_VOICES];

  // transaction payload and working values
  logic [1:0]            cmd_q, cmd_d;
  logic [6:0]            note_q, note_d;
  logic [6:0]            vel_q, vel_d;
  logic [2:0]            rv_q, rv_d;
  logic [15:0]           lvl_q, lvl_d;
  logic [VW-1:0]         best_q, best_d;
  logic                  best_rel_q, best_rel_d;
  logic [15:0]           best_lvl_q, best_lvl_d;
  logic                  rs_start_q, rs_start_d;
  logic                  rs_assign_q, rs_assign_d;
  logic [VW-1:0]         rs_idx_q, rs_idx_d;
  logic [6:0]            rs_note_q, rs_note_d;
  logic [6:0]            rs_vel_q, rs_vel_d;
  logic                  rs_rp_q, rs_rp_d;
  logic [NUM_VOICES-1:0] rs_rel_q, rs_rel_d;

  // output register
  logic                  o_start_q;
  logic                  o_assign_q;
  logic [VW-1:0]         o_idx_q;
  logic [6:0]            o_note_q;
  logic [6:0]            o_vel_q;
  logic                  o_rp_q;
  logic [NUM_VOICES-1:0] o_rel_q;

  // held-note list memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [6:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [6:0]    ram_rdata;

  logic [CW-1:0] tail_cnt;
  logic [VW-1:0] scan_idx;
  logic [VW-1:0] rv_idx;
  logic [VW-1:0] tidx;
  logic          rv_ok;
  logic          push_ok;
  logic          scan_upd;

  assign tail_cnt = cnt_q - CW'(1);
  assign scan_idx = si_q[VW-1:0];
  assign rv_idx   = VW'(rv_q);
  assign rv_ok    = (32'(rv_q) < NUM_VOICES);
  assign push_ok  = (cnt_q < CW'(HELD_DEPTH));
  assign tidx     = (mode_q == MODE_POLY) ? best_q : '0;

  // released voices win over held ones, then the lower level, then the lower index
  assign scan_upd = (vrel_q[scan_idx] == best_rel_q) ? (vlvl_q[scan_idx] < best_lvl_q)
                                                     : vrel_q[scan_idx];

  always_comb begin
    ram_raddr = (ctl_i.op == OP_TAIL_RD) ? tail_cnt[AW-1:0] : rd_q[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = wr_q[AW-1:0];
    ram_wdata = ram_rdata;
    if (ctl_i.op == OP_DROP_WR && ram_rdata != note_q) begin
      ram_we = 1'b1;
    end else if (ctl_i.op == OP_NOTE_ON && push_ok) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = note_q;
    end
  end

  always_comb begin
    logic nst;
    logic nas;
    logic nrp;
    nst         = 1'b0;
    nas         = 1'b0;
    nrp         = 1'b0;
    mode_d      = cfg_we_i ? cfg_wdata_i : mode_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    si_d        = si_q;
    vnote_d     = vnote_q;
    vrel_d      = vrel_q;
    vlvl_d      = vlvl_q;
    cmd_d       = cmd_q;
    note_d      = note_q;
    vel_d       = vel_q;
    rv_d        = rv_q;
    lvl_d       = lvl_q;
    best_d      = best_q;
    best_rel_d  = best_rel_q;
    best_lvl_d  = best_lvl_q;
    rs_start_d  = rs_start_q;
    rs_assign_d = rs_assign_q;
    rs_idx_d    = rs_idx_q;
    rs_note_d   = rs_note_q;
    rs_vel_d    = rs_vel_q;
    rs_rp_d     = rs_rp_q;
    rs_rel_d    = rs_rel_q;
    case (ctl_i.op)
      OP_LATCH: begin
        // note on with zero velocity is handled as note off
        cmd_d       = (cmd_i == CMD_NOTE_ON && note_velocity_i == 7'd0) ? CMD_NOTE_OFF
                                                                         : cmd_i;
        note_d      = note_number_i;
        vel_d       = note_velocity_i;
        rv_d        = report_voice_i;
        lvl_d       = report_level_i;
        rs_start_d  = 1'b0;
        rs_assign_d = 1'b0;
        rs_idx_d    = '0;
        rs_note_d   = '0;
        rs_vel_d    = '0;
        rs_rp_d     = 1'b0;
        rs_rel_d    = '0;
      end
      OP_DROP_INIT: begin
        rd_d = '0;
        wr_d = '0;
      end
      OP_DROP_WR: begin
        rd_d = rd_q + CW'(1);
        if (ram_rdata != note_q) begin
          wr_d = wr_q + CW'(1);
        end
      end
      OP_DROP_END: begin
        cnt_d = wr_q;
      end
      OP_POLY_REL: begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (vnote_q[i] == note_q) begin
            vrel_d[i]   = 1'b1;
            rs_rel_d[i] = 1'b1;
          end
        end
      end
      OP_MONO_REL: begin
        vrel_d[0]   = 1'b1;
        rs_rel_d[0] = 1'b1;
      end
      OP_MONO_TAIL: begin
        rs_assign_d = 1'b1;
        rs_note_d   = ram_rdata;
        vnote_d[0]  = ram_rdata;
      end
      OP_SCAN_INIT: begin
        best_d     = '0;
        best_rel_d = vrel_q[0];
        best_lvl_d = vlvl_q[0];
        si_d       = SW'(1);
      end
      OP_SCAN_STEP: begin
        if (scan_upd) begin
          best_d     = scan_idx;
          best_rel_d = vrel_q[scan_idx];
          best_lvl_d = vlvl_q[scan_idx];
        end
        si_d = si_q + SW'(1);
      end
      OP_NOTE_ON: begin
        case (mode_q)
          MODE_POLY: begin
            nst = 1'b1;
            nas = 1'b1;
            nrp = 1'b1;
          end
          MODE_MONO: begin
            nst = 1'b1;
            nas = 1'b1;
          end
          MODE_LEGATO: begin
            nas = 1'b1;
            nst = (cnt_q == '0);
            nrp = (cnt_q == '0);
          end
          default: begin
            nas = 1'b0;
          end
        endcase
        rs_start_d  = nst;
        rs_assign_d = nas;
        rs_rp_d     = nrp;
        if (nas) begin
          rs_idx_d      = tidx;
          rs_note_d     = note_q;
          vnote_d[tidx] = note_q;
          if (nst) begin
            rs_vel_d     = vel_q;
            vrel_d[tidx] = 1'b0;
          end
        end
        if (push_ok) begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      OP_ALL_OFF: begin
        vrel_d   = '1;
        rs_rel_d = '1;
      end
      OP_REPORT: begin
        if (rv_ok) begin
          vlvl_d[rv_idx] = lvl_q;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
      cnt_q  <= '0;
      rd_q   <= '0;
      wr_q   <= '0;
      si_q   <= '0;
      vrel_q <= '1;
      for (int i = 0; i < NUM_VOICES; i++) begin
        vnote_q[i] <= '0;
        vlvl_q[i]  <= '0;
      end
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      si_q    <= si_d;
      vrel_q  <= vrel_d;
      vnote_q <= vnote_d;
      vlvl_q  <= vlvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    note_q      <= note_d;
    vel_q       <= vel_d;
    rv_q        <= rv_d;
    lvl_q       <= lvl_d;
    best_q      <= best_d;
    best_rel_q  <= best_rel_d;
    best_lvl_q  <= best_lvl_d;
    rs_start_q  <= rs_start_d;
    rs_assign_q <= rs_assign_d;
    rs_idx_q    <= rs_idx_d;
    rs_note_q   <= rs_note_d;
    rs_vel_q    <= rs_vel_d;
    rs_rp_q     <= rs_rp_d;
    rs_rel_q    <= rs_rel_d;
    if (ctl_i.emit) begin
      o_start_q  <= rs_start_q;
      o_assign_q <= rs_assign_q;
      o_idx_q    <= rs_idx_q;
      o_note_q   <= rs_note_q;
      o_vel_q    <= rs_vel_q;
      o_rp_q     <= rs_rp_q;
      o_rel_q    <= rs_rel_q;
    end
  end

  svalloc_ram #(
    .WIDTH (7),
    .DEPTH (HELD_DEPTH),
    .AW    (AW)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.eff_cmd   = cmd_q;
  assign sts_o.mode      = mode_q;
  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.drop_done = (rd_q == cnt_q);
  assign sts_o.scan_done = (si_q == SW'(NUM_VOICES));

  assign start_voice_o     = o_start_q;
  assign assign_note_o     = o_assign_q;
  assign target_index_o    = 3'(o_idx_q);
  assign target_note_o     = o_note_q;
  assign target_velocity_o = o_vel_q;
  assign reset_pitch_o     = o_rp_q;
  assign release_mask_o    = 8'(o_rel_q);

  `SVALLOC_ASSERT_STD(a_compact_order, wr_q <= rd_q, "compaction write pointer passed read pointer")
  `SVALLOC_ASSERT_STD(a_count_bound, cnt_q <= HELD_DEPTH, "held-note count beyond list depth")
  `SVALLOC_ASSERT_STD(a_drop_shrinks, (ctl_i.op == OP_DROP_END) |=> (cnt_q <= $past(cnt_q)), "note removal grew the held list")

endmodule

`default_nettype wire
